// File: sv/rtcms_pkg.sv
// Shared types and conversion constants for the millisecond timekeeper.
`timescale 1ns / 1ps

package rtcms_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_SET   = 2'd2,
        FUNC_SLEEP = 2'd3
    } func_t;

    // Exact v / 125 for any 32-bit v: (v * SET_RECIP) >> SET_SHIFT
    localparam logic [32:0] SET_RECIP  = 33'd4398046512;
    localparam int          SET_SHIFT  = 39;
    // Exact x / 125 for x below 16384: (x * FRAC_RECIP) >> FRAC_SHIFT
    localparam logic [14:0] FRAC_RECIP = 15'd16778;
    localparam int          FRAC_SHIFT = 21;
    localparam logic [13:0] FRAC_ROUND = 14'd62;

    typedef struct packed {
        func_t       func;
        logic [31:0] set_ticks;
        logic [31:0] sleep_ticks;
    } rtcms_item_t;

    typedef struct packed {
        logic [31:0] ticks;
        logic        wake;
        logic        asleep;
    } rtcms_result_t;

endpackage

// File: sv/rtc_millisecond_timekeeper.sv
// Top level of the millisecond timekeeper on a 1024 Hz tick count.
// A beat accepted on in_ready moves through the input, divide and conversion stages, and
// the core's state update writes it into the result stage, which drives out_valid.
// Throughput: one beat per cycle, with out_ready high; the core update sets this pace.
// Reset: rst_n clears all stage valids and the tick, sleep and compare state at once.
`timescale 1ns / 1ps

module rtc_millisecond_timekeeper #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] millis_now,
    output logic        wake,
    output logic        asleep
);
    import rtcms_pkg::*;

    // Stage valids; each stage moves when the one after it has room
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, res_valid_reg;
    logic en1, en2, en3, en_res;

    // Stage 1: raw beat
    func_t       s1_func_reg;
    logic [31:0] s1_value_reg;

    // Stage 2: quotient by 125 and sleep ticks
    func_t       s2_func_reg;
    logic [6:0]  s2_vlow_reg;
    logic [25:0] s2_quot_reg;
    logic [31:0] s2_sleep_reg;

    // Stage 3: converted operands for the core
    rtcms_item_t s3_item_reg;

    // Result stage
    rtcms_result_t res_reg;
    rtcms_result_t core_result;

    assign en_res   = !res_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en_res;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en_res)
                res_valid_reg <= s3_valid_reg;
        end
    end

    // Divide by 125 through the reciprocal; the sleep conversion is a shift-add
    logic [64:0] quot_prod;
    logic [25:0] quot;
    logic [31:0] sleep_ticks;

    assign quot_prod   = {33'd0, s1_value_reg} * {32'd0, SET_RECIP};
    assign quot        = quot_prod[SET_SHIFT+25:SET_SHIFT];
    assign sleep_ticks = s1_value_reg + (s1_value_reg >> 6) + (s1_value_reg >> 7)
                       + (s1_value_reg >> 11) + (s1_value_reg >> 14);

    // Remainder mod 128 is enough since it stays below 125:
    // v - 125q = v - 128q + 3q
    logic [6:0]  rem;
    logic [13:0] frac_num;
    logic [28:0] frac_prod;
    logic [6:0]  frac;

    assign rem       = s2_vlow_reg + {s2_quot_reg[5:0], 1'b0} + s2_quot_reg[6:0];
    assign frac_num  = {rem, 7'd0} + FRAC_ROUND;
    assign frac_prod = {15'd0, frac_num} * {14'd0, FRAC_RECIP};
    assign frac      = frac_prod[FRAC_SHIFT+6:FRAC_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_func_reg  <= func_t'(func);
            s1_value_reg <= value;
        end
        if (en2)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_vlow_reg  <= s1_value_reg[6:0];
            s2_quot_reg  <= quot;
            s2_sleep_reg <= sleep_ticks;
        end
        if (en3)
        begin
            s3_item_reg.func        <= s2_func_reg;
            // frac is below 128, so it fills the low bits of q << 7
            s3_item_reg.set_ticks   <= {s2_quot_reg[24:0], frac};
            s3_item_reg.sleep_ticks <= s2_sleep_reg;
        end
        if (en_res)
            res_reg <= core_result;
    end

    // Advance the state exactly once per beat, as it enters the result stage
    rtcms_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s3_valid_reg && en_res),
        .item   (s3_item_reg),
        .result (core_result)
    );

    // ticks * 1000 / 1024 with the rounding correction on the low seven bits
    function automatic logic [31:0] ticks_to_ms(input logic [31:0] m);
        logic [7:0] rsum;
        rsum = {2'b00, m[5:0]} + {2'b00, m[6:1]} + 8'd32;
        return m - (m >> 6) - (m >> 7) - {30'd0, rsum[7:6]};
    endfunction

    assign out_valid  = res_valid_reg;
    assign millis_now = ticks_to_ms(res_reg.ticks);
    assign wake       = res_reg.wake;
    assign asleep     = res_reg.asleep;

    // A beat that wakes never reports a sleep still running
    a_wake_not_asleep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake) |-> !asleep)
        else $error("wake reported while still asleep");

    // An accepted beat lands in the input stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted beat lost at the input stage");

    // A beat leaving stage 3 shows up as a result
    a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && en_res) |=> out_valid)
        else $error("updated beat missing at the result stage");

endmodule

// File: sv/rtcms_core.sv
// Timekeeper state: tick count, sleep chunking and wake decision.
`timescale 1ns / 1ps

module rtcms_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  rtcms_pkg::rtcms_item_t item,
    output rtcms_pkg::rtcms_result_t result
);
    import rtcms_pkg::*;

    localparam int PAD = 32 - COUNTER_BITS;
    localparam logic [COUNTER_BITS-1:0] LOW_MASK = '1;

    logic [31:0]             tick_count_reg, tick_count_next;
    logic [31:0]             remaining_reg, remaining_next;
    logic [COUNTER_BITS-1:0] match_reg, match_next;
    logic                    sleeping_reg, sleeping_next;
    logic                    wake;

    logic [COUNTER_BITS-1:0] low;
    logic [31:0]             src;
    logic [COUNTER_BITS-1:0] base;
    logic [COUNTER_BITS-1:0] chunk;
    logic [31:0]             rest;
    logic [COUNTER_BITS-1:0] chunk_match;

    assign low = tick_count_reg[COUNTER_BITS-1:0];

    // One chunk splitter serves both the sleep start and the chunk rollover
    always_comb
    begin
        if (item.func == FUNC_SLEEP)
        begin
            src  = item.sleep_ticks;
            base = low;
        end
        else
        begin
            src  = remaining_reg;
            base = low + 1'b1;
        end
        if (src > {{PAD{1'b0}}, LOW_MASK})
            chunk = LOW_MASK;
        else
            chunk = src[COUNTER_BITS-1:0];
        rest        = src - {{PAD{1'b0}}, chunk};
        chunk_match = base + chunk - 1'b1;
    end

    always_comb
    begin
        tick_count_next = tick_count_reg;
        remaining_next  = remaining_reg;
        match_next      = match_reg;
        sleeping_next   = sleeping_reg;
        wake            = 1'b0;
        case (item.func)
            FUNC_TICK:
            begin
                if (sleeping_reg && (low == match_reg))
                begin
                    if (remaining_reg == 32'd0)
                    begin
                        sleeping_next = 1'b0;
                        wake          = 1'b1;
                    end
                    else
                    begin
                        remaining_next = rest;
                        match_next     = chunk_match;
                    end
                end
                tick_count_next = tick_count_reg + 32'd1;
            end
            FUNC_SET:
            begin
                tick_count_next = item.set_ticks;
            end
            FUNC_SLEEP:
            begin
                if (item.sleep_ticks == 32'd0)
                begin
                    sleeping_next  = 1'b0;
                    remaining_next = 32'd0;
                    wake           = 1'b1;
                end
                else
                begin
                    remaining_next = rest;
                    match_next     = chunk_match;
                    sleeping_next  = 1'b1;
                end
            end
            default:
            begin
                tick_count_next = tick_count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            remaining_reg  <= '0;
            match_reg      <= '0;
            sleeping_reg   <= 1'b0;
        end
        else if (step)
        begin
            tick_count_reg <= tick_count_next;
            remaining_reg  <= remaining_next;
            match_reg      <= match_next;
            sleeping_reg   <= sleeping_next;
        end
    end

    assign result.ticks  = tick_count_next;
    assign result.wake   = wake;
    assign result.asleep = sleeping_next;

    // Ticks still owed always belong to a running sleep
    a_remaining_sleeping: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg != 32'd0) |-> sleeping_reg)
        else $error("ticks remain with no sleep running");

    // A wake ends the sleep in the same update
    a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && wake) |=> !sleeping_reg)
        else $error("sleep still running after wake");

    // The count moves only on a stepped item
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(tick_count_reg))
        else $error("tick count changed without an item");

endmodule

// File: bench/rtc_millisecond_timekeeper_test.sv
// Self-checking testbench for the 1024 Hz millisecond timekeeper.
`timescale 1ns / 1ps

module rtc_millisecond_timekeeper_test;

    import rtcms_pkg::*;

    localparam int          COUNTER_BITS = 16;
    localparam logic [31:0] LOW_MASK     = 32'h0000_FFFF;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    // Leave the four-stage pipe plenty of room to empty at the end.
    localparam int          TAIL_CYCLES  = 12;

    // One result beat as the checker sees it.
    typedef struct packed {
        logic [31:0] millis;
        logic        wake;
        logic        asleep;
    } clock_reading_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    func_t       func;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] millis_now;
    logic        wake;
    logic        asleep;

    // Predicted timekeeper state, updated on every accepted input beat.
    logic [31:0] clk_ticks;
    logic [31:0] sleep_left;
    logic [15:0] chunk_match;
    logic        sleep_active;

    clock_reading_t expected_readings[$];
    int             beats_sent;
    int             fail_count;
    int             cycle_count;
    int             sink_hold;
    logic           sender_steady;
    logic           sink_steady;

    rtc_millisecond_timekeeper #(
        .COUNTER_BITS(COUNTER_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .millis_now(millis_now),
        .wake      (wake),
        .asleep    (asleep)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Conversions, written out in plain 32-bit arithmetic
    // ------------------------------------------------------------------

    // ticks * 1000 / 1024 with the shift-and-round correction term
    function automatic logic [31:0] ms_from_ticks(logic [31:0] m);
        logic [31:0] r;
        r = ((m & 32'h3f) + ((m & 32'h7f) >> 1) + 32'd32) >> 6;
        return m - (m >> 6) - (m >> 7) - r;
    endfunction

    // round(ms * 128 / 125), split so nothing overflows before the wrap
    function automatic logic [31:0] ticks_from_set_ms(logic [31:0] v);
        return ((v / 32'd125) << 7) + (((v % 32'd125) << 7) + 32'd62) / 32'd125;
    endfunction

    // Sleep conversion kept in 64 bits; the block uses the low 32 bits.
    function automatic longint unsigned sleep_ticks_wide(logic [31:0] v);
        longint unsigned w;
        w = {32'd0, v};
        return w + (w >> 6) + (w >> 7) + (w >> 11) + (w >> 14);
    endfunction

    // Smallest sleep request whose unwrapped tick count reaches the target.
    function automatic logic [31:0] sleep_ms_for(longint unsigned target);
        longint unsigned v;
        v = (target * 64'd16384) / 64'd16777;
        v = (v > 64'd8) ? v - 64'd8 : 64'd0;
        while (sleep_ticks_wide(v[31:0]) < target)
            v++;
        return v[31:0];
    endfunction

    // A set request that lands on the target tick or at most one below it.
    function automatic logic [31:0] set_ms_below(logic [31:0] target);
        longint unsigned w;
        w = {32'd0, target};
        w = (w * 64'd125) >> 7;
        return w[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Carve the next chunk off the pending sleep, starting at counter value low.
    function automatic void open_chunk(logic [15:0] low);
        logic [31:0] c;
        c = (sleep_left > LOW_MASK) ? LOW_MASK : sleep_left;
        sleep_left = sleep_left - c;
        chunk_match = low + c[15:0] - 16'd1;
    endfunction

    function automatic clock_reading_t advance_clock(func_t f, logic [31:0] v);
        clock_reading_t  r;
        longint unsigned wide;
        logic [31:0]     t;
        logic [15:0]     low;
        r.wake = 1'b0;
        low = clk_ticks[15:0];
        case (f)
            FUNC_TICK:
            begin
                // Check the compare before the count moves on.
                if (sleep_active && low == chunk_match)
                begin
                    if (sleep_left == 32'd0)
                    begin
                        sleep_active = 1'b0;
                        r.wake = 1'b1;
                    end
                    else
                        open_chunk(low + 16'd1);
                end
                clk_ticks = clk_ticks + 32'd1;
            end
            FUNC_SET:
                clk_ticks = ticks_from_set_ms(v);
            FUNC_SLEEP:
            begin
                wide = sleep_ticks_wide(v);
                t = wide[31:0];
                if (t == 32'd0)
                begin
                    // Nothing to wait for: wake on the request itself.
                    sleep_active = 1'b0;
                    sleep_left = 32'd0;
                    r.wake = 1'b1;
                end
                else
                begin
                    sleep_left = t;
                    open_chunk(low);
                    sleep_active = 1'b1;
                end
            end
            default:
                ;
        endcase
        r.millis = ms_from_ticks(clk_ticks);
        r.asleep = sleep_active;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Lean on the extremes as well as fully random words.
    function automatic logic [31:0] any_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Drive one beat, hold it until accepted, then log its expected result.
    task automatic send_beat(func_t f, logic [31:0] v);
        int gap;
        gap = sender_steady ? 0 : idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        expected_readings.push_back(advance_clock(f, v));
        beats_sent++;
    endtask

    // Drop valid and hold off until every pending result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // Walk a sleep through its chunks. Far-off compares are reached by
    // setting the count just short of them, then ticking across.
    task automatic run_out_sleep(int max_chunks, int max_lead);
        int          chunks;
        int          guard;
        logic [15:0] gap_to_match;
        logic [15:0] hi;
        logic [31:0] target;
        chunks = 0;
        while (sleep_active && chunks < max_chunks)
        begin
            gap_to_match = chunk_match - clk_ticks[15:0];
            if (gap_to_match > 16'd40)
            begin
                hi = 16'($urandom_range(0, 16'hFFFF));
                target = {hi, chunk_match} - 32'($urandom_range(0, max_lead));
                send_beat(FUNC_SET, set_ms_below(target));
            end
            guard = 0;
            while (sleep_active && clk_ticks[15:0] != chunk_match && guard < 64)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(FUNC_READ, $urandom);
                send_beat(FUNC_TICK, $urandom);
                guard++;
            end
            // This tick sees the compare hit.
            if (sleep_active && clk_ticks[15:0] == chunk_match)
                send_beat(FUNC_TICK, $urandom);
            chunks++;
        end
    endtask

    // One randomly chosen sequence; well-formed sleeps are the most frequent kind.
    task automatic random_scenario();
        int          pick;
        int          n;
        logic [31:0] ms;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            n = $urandom_range(0, 9);
            ms = (n < 6) ? $urandom_range(1, 40) :
                 (n < 9) ? $urandom_range(41, 70000) : $urandom_range(70001, 250000);
            send_beat(FUNC_SLEEP, ms);
            if ($urandom_range(0, 3) == 0)
                send_beat(FUNC_READ, $urandom);
            run_out_sleep(8, 5);
        end
        else if (pick < 60)
            send_beat(func_t'($urandom_range(0, 3)), any_value());
        else if (pick < 75)
        begin
            // Break a sleep off partway: replace it, or move the count under it.
            send_beat(FUNC_SLEEP,
                      ($urandom_range(0, 1) == 0) ? $urandom_range(1, 60) : any_value());
            repeat ($urandom_range(0, 5))
                send_beat(FUNC_TICK, $urandom);
            if ($urandom_range(0, 1) == 0)
                send_beat(FUNC_SLEEP, any_value());
            else
                send_beat(FUNC_SET, any_value());
            run_out_sleep(4, 5);
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(1, 20))
                send_beat(FUNC_TICK, $urandom);
        end
        else
        begin
            send_beat(FUNC_SET, any_value());
            send_beat(FUNC_READ, any_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_state();
        send_beat(FUNC_READ, 32'hFFFF_FFFF);
        send_beat(FUNC_TICK, 32'd0);
    endtask

    task automatic test_set_extremes();
        int guard;
        send_beat(FUNC_SET, 32'd0);
        send_beat(FUNC_SET, 32'hFFFF_FFFF);
        send_beat(FUNC_SET, 32'd125);
        // Park the count at the top and tick it through the 32-bit wrap.
        send_beat(FUNC_SET, set_ms_below(32'hFFFF_FFFF));
        guard = 0;
        while (clk_ticks != 32'd0 && guard < 8)
        begin
            send_beat(FUNC_TICK, 32'hFFFF_FFFF);
            guard++;
        end
    endtask

    task automatic test_sleep_cases();
        // Zero-length sleep, then one whose tick count wraps round to zero.
        send_beat(FUNC_SLEEP, 32'd0);
        send_beat(FUNC_SLEEP, sleep_ms_for(64'h1_0000_0000));
        // One-tick sleep wakes on the very next tick.
        send_beat(FUNC_SLEEP, 32'd1);
        send_beat(FUNC_TICK, 32'd0);
        // The longest request gets replaced and must never wake.
        send_beat(FUNC_SLEEP, 32'hFFFF_FFFF);
        send_beat(FUNC_SLEEP, 32'd3);
        run_out_sleep(1, 0);
        // Move the count while a chunk is pending.
        send_beat(FUNC_SLEEP, 32'd20);
        send_beat(FUNC_READ, 32'd0);
        send_beat(FUNC_SET, 32'h0012_3456);
        run_out_sleep(2, 0);
        // Exactly one full chunk, then one tick past it.
        send_beat(FUNC_SLEEP, sleep_ms_for(64'd65535));
        run_out_sleep(2, 0);
        send_beat(FUNC_SLEEP, sleep_ms_for(64'd65536));
        run_out_sleep(3, 0);
    endtask

    task automatic test_back_to_back(int n);
        int start;
        start = beats_sent;
        sender_steady = 1'b1;
        sink_steady = 1'b1;
        while (beats_sent - start < n)
            random_scenario();
        sender_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_result_pause();
        repeat (6)
            random_scenario();
        wait_for_results();
        repeat (6)
            random_scenario();
    endtask

    task automatic test_random_mix(int n);
        int start;
        start = beats_sent;
        while (beats_sent - start < n)
            random_scenario();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel at random, with steady stretches on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (sink_steady)
            out_ready <= 1'b1;
        else if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_hold = idle_len();
        end
    end

    // Compare every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        clock_reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("result beat arrived with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (millis_now !== want.millis)
                begin
                    $error("millis_now: expected %0d, got %0d", want.millis, millis_now);
                    fail_count++;
                end
                if (wake !== want.wake)
                begin
                    $error("wake: expected %0b, got %0b", want.wake, wake);
                    fail_count++;
                end
                if (asleep !== want.asleep)
                begin
                    $error("asleep: expected %0b, got %0b", want.asleep, asleep);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_TICK;
        value         = 32'd0;
        out_ready     = 1'b0;
        clk_ticks     = 32'd0;
        sleep_left    = 32'd0;
        chunk_match   = 16'd0;
        sleep_active  = 1'b0;
        beats_sent    = 0;
        fail_count    = 0;
        cycle_count   = 0;
        sink_hold     = 0;
        sender_steady = 1'b0;
        sink_steady   = 1'b0;

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_set_extremes();
        test_sleep_cases();
        test_back_to_back(200);
        test_result_pause();
        test_random_mix(1750);

        // Drain the pipe, then give it a few idle cycles to show strays.
        wait_for_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/rtcms_pkg.sv
sv/rtcms_core.sv
sv/rtc_millisecond_timekeeper.sv
bench/rtc_millisecond_timekeeper_test.sv
